/* rtl/binary_square_dilation_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the dilation block checkers.
// ----------------------------------------------------------------------------
`ifndef BINARY_SQUARE_DILATION_ASSERT_SVH
`define BINARY_SQUARE_DILATION_ASSERT_SVH

// same-cycle implication
`define BSD_ASSERT_IMPL(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BSD_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/bsd_pkg.sv */
// ----------------------------------------------------------------------------
// bsd_pkg
// Types and constants of the binary square dilation block.
// ----------------------------------------------------------------------------
package bsd_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic cmd;
        logic contour_bit;
        logic base_bit;
    } t_in_item;

    typedef struct packed {
        logic pixel_on;
        logic row_end;
        logic frame_end;
    } t_out_item;

endpackage

/* rtl/binary_square_dilation.sv */
// An accepted input is registered in stage 1, its results then in the queue.
// Throughput: one input transaction per cycle while the result queue has room;
// the last pixel of a row yields up to RADIUS+1 results, drained one per cycle
// while the output is taken. Reset: synchronous, active low; then a clearing pass
// zeroes all MAX_WIDTH line memory entries, input not ready (config always taken).
// ----------------------------------------------------------------------------
// binary_square_dilation
// Streaming SPAN x SPAN (5x5 at RADIUS 2) square dilation of a contour bit plane,
// ORed with a base bit plane, in raster order with line memory.
// ----------------------------------------------------------------------------
module binary_square_dilation #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int RADIUS     = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  bsd_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output bsd_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bsd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [bsd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int SPAN  = 2 * RADIUS + 1;
    localparam int LW    = 2 * RADIUS;
    localparam int MW    = 3 * RADIUS;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + RADIUS);
    localparam int CMPW  = (WW > HW ? WW : HW) > bsd_pkg::CFG_DATA_W ?
                           (WW > HW ? WW : HW) : bsd_pkg::CFG_DATA_W;
    localparam int NRES  = RADIUS + 1;
    localparam int QD    = 2 * NRES + 1;
    localparam int QCW   = $clog2(QD + 1);
    localparam int QIW   = $clog2(QD);
    localparam int RST_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int RST_H = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

    // configuration, stored clamped
    logic [WW-1:0]   r_w;
    logic [HW-1:0]   r_h;
    logic [CMPW-1:0] cfg_ext;
    logic [WW-1:0]   cfg_w;
    logic [HW-1:0]   cfg_h;

    // raster counters and clear pass
    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic            r_clr;
    logic [CW-1:0]   r_clr_addr;

    // line memory: {base delay, contour history}
    logic [MW-1:0]   mem [MAX_WIDTH];
    logic [MW-1:0]   r_rd;
    logic            r_fwd;
    logic [MW-1:0]   r_fwd_data;

    // stage 1
    logic            r_s1_v;
    logic [CW-1:0]   r_s1_c;
    logic            r_s1_cb;
    logic            r_s1_bb;
    logic            r_s1_last;
    logic            r_s1_emit;
    logic            r_s1_fe_row;
    logic            r_s1_c_zero;
    logic [LW-1:0]   r_s1_mask;
    logic [RADIUS:0] r_s1_cge;
    logic [SPAN-1:0] r_win;
    logic [RADIUS:0] r_pipe;

    // result queue
    bsd_pkg::t_out_item r_q [QD];
    bsd_pkg::t_out_item n_q [QD];
    logic [QCW-1:0]     r_cnt;
    logic [QCW-1:0]     n_cnt;

    logic               in_acc;
    logic               pop;
    logic               virt;
    logic               last;
    logic [RW:0]        row_x;
    logic [RW:0]        h_x;
    logic [LW-1:0]      mask;
    logic [RADIUS:0]    cge;
    logic [MW-1:0]      old;
    logic [LW-1:0]      old_line;
    logic [RADIUS-1:0]  old_base;
    logic               vert;
    logic [LW:0]        line_sh;
    logic [RADIUS:0]    base_sh;
    logic [MW-1:0]      n_wdata;
    logic [SPAN-1:0]    win;
    logic [RADIUS:0]    pipe;
    logic [SPAN-1:0]    win_k;
    logic [RADIUS:0]    pipe_k;
    bsd_pkg::t_out_item res [NRES];
    logic [NRES-1:0]    res_v;
    logic [QCW+1:0]     need;

    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign pop         = o_out_valid && i_out_ready;
    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_q[0];

    // queue room: stored results, exact stage 1 pushes, worst case of the new item
    always_comb begin
        need = (QCW+2)'(r_cnt) + (QCW+2)'(NRES);
        if (r_s1_v) begin
            for (int k = 0; k <= RADIUS; k++) begin
                need = need + (QCW+2)'(res_v[k]);
            end
        end
    end

    assign o_in_ready = !r_clr && (need <= (QCW+2)'(QD));

    // config clamp
    always_comb begin
        cfg_ext = CMPW'(i_cfg_data);
        if (cfg_ext == '0) begin
            cfg_w = WW'(1);
        end else if (cfg_ext > CMPW'(MAX_WIDTH)) begin
            cfg_w = WW'(MAX_WIDTH);
        end else begin
            cfg_w = WW'(cfg_ext);
        end
        if (cfg_ext == '0) begin
            cfg_h = HW'(1);
        end else if (cfg_ext > CMPW'(MAX_HEIGHT)) begin
            cfg_h = HW'(MAX_HEIGHT);
        end else begin
            cfg_h = HW'(cfg_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= WW'(RST_W);
            r_h <= HW'(RST_H);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bsd_pkg::REG_IMAGE_WIDTH: begin
                    r_w <= cfg_w;
                end
                bsd_pkg::REG_IMAGE_HEIGHT: begin
                    r_h <= cfg_h;
                end
                default: begin
                end
            endcase
        end
    end

    // accept-side decode
    always_comb begin
        row_x = (RW+1)'(r_row);
        h_x   = (RW+1)'(r_h);
        virt  = (i_in_data.cmd == bsd_pkg::CMD_FLUSH) || (row_x >= h_x);
        last  = (WW'(r_col) + WW'(1)) >= r_w;
        for (int j = 0; j < LW; j++) begin
            mask[j] = row_x > (RW+1)'(j);
        end
        for (int k = 0; k <= RADIUS; k++) begin
            cge[k] = r_col >= CW'(RADIUS - k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_s1_v     <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + CW'(1);
                if (r_clr_addr == CW'(MAX_WIDTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            r_s1_v <= in_acc;
            if (in_acc) begin
                r_fwd <= r_s1_v && (r_s1_c == r_col);
                if (last) begin
                    r_col <= '0;
                    if ((row_x + (RW+1)'(1)) >= (h_x + (RW+1)'(RADIUS))) begin
                        r_row <= '0;
                    end else begin
                        r_row <= r_row + RW'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_c      <= r_col;
            r_s1_cb     <= virt ? 1'b0 : i_in_data.contour_bit;
            r_s1_bb     <= virt ? 1'b0 : i_in_data.base_bit;
            r_s1_last   <= last;
            r_s1_emit   <= (row_x >= (RW+1)'(RADIUS)) && (row_x < h_x + (RW+1)'(RADIUS));
            r_s1_fe_row <= row_x == (h_x + (RW+1)'(RADIUS - 1));
            r_s1_c_zero <= r_col == '0;
            r_s1_mask   <= mask;
            r_s1_cge    <= cge;
            r_fwd_data  <= n_wdata;
        end
    end

    // line memory
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            mem[r_clr_addr] <= '0;
        end else if (r_s1_v) begin
            mem[r_s1_c] <= n_wdata;
        end
        if (in_acc) begin
            r_rd <= mem[r_col];
        end
    end

    // stage 1 compute
    always_comb begin
        old      = r_fwd ? r_fwd_data : r_rd;
        old_line = old[LW-1:0];
        old_base = old[MW-1:LW];
        vert     = r_s1_cb || ((old_line & r_s1_mask) != '0);
        line_sh  = {old_line, r_s1_cb};
        base_sh  = {old_base, r_s1_bb};
        n_wdata  = {base_sh[RADIUS-1:0], line_sh[LW-1:0]};
        win      = {(r_s1_c_zero ? (SPAN-1)'(0) : r_win[SPAN-2:0]), vert};
        pipe     = {(r_s1_c_zero ? RADIUS'(0) : r_pipe[RADIUS-1:0]), old_base[RADIUS-1]};
        for (int k = 0; k <= RADIUS; k++) begin
            win_k  = win << k;
            pipe_k = pipe << k;
            res[k].pixel_on  = (win_k != '0) || pipe_k[RADIUS];
            res[k].row_end   = (k == RADIUS);
            res[k].frame_end = (k == RADIUS) && r_s1_fe_row;
            if (k == 0) begin
                res_v[k] = r_s1_emit && r_s1_cge[k];
            end else begin
                res_v[k] = r_s1_last && r_s1_emit && r_s1_cge[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_pipe <= '0;
        end else if (r_s1_v) begin
            r_win  <= win;
            r_pipe <= pipe;
        end
    end

    // result queue: pop at head, append this item's results at tail
    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (pop) begin
            for (int i = 0; i < QD - 1; i++) begin
                n_q[i] = r_q[i+1];
            end
            n_cnt = n_cnt - QCW'(1);
        end
        if (r_s1_v) begin
            for (int k = 0; k <= RADIUS; k++) begin
                if (res_v[k]) begin
                    n_q[n_cnt[QIW-1:0]] = res[k];
                    n_cnt = n_cnt + QCW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule

/* rtl/bsd_checker.sv */
// ----------------------------------------------------------------------------
// bsd_checker
// Port-level checks for the binary square dilation block, bound to the top.
// ----------------------------------------------------------------------------
`include "binary_square_dilation_assert.svh"

module bsd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_in_ready,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  bsd_pkg::t_out_item o_out_data
);

    `BSD_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `BSD_ASSERT_NEXT(a_out_stable, i_clk, !i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_data))
    `BSD_ASSERT_IMPL(a_frame_row_end, i_clk, !i_rst_n, o_out_valid && o_out_data.frame_end, o_out_data.row_end)
    `BSD_ASSERT_NEXT(a_reset_quiet, i_clk, 1'b0, !i_rst_n, !o_out_valid && !o_in_ready)

endmodule

bind binary_square_dilation bsd_checker u_bsd_checker (.*);
